### sv/par_pkg.sv
// Package for the pressure alarm reporter: field widths, codes, the command
// and configuration structs, and the Modbus CRC-16 byte update.
// No dependencies; every other file refers to it by scoped names.
package par_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int IN_CHANNELS = 7;
    localparam int SUM_W       = 19;
    localparam int LIMIT_W     = 10;
    localparam int ADDR_W      = 8;
    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int FLAG_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;
    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = 24;

    localparam int CHANNELS_DEF            = 7;
    localparam int SAMPLES_PER_AVERAGE_DEF = 100;
    localparam int REPORT_WORDS_DEF        = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // floor(sum * 10 / 4095) equals (sum * SCALE_MULT) >> SCALE_SHIFT for any 19-bit sum.
    localparam int          SCALE_SHIFT = 35;
    localparam int          MULT_W      = 27;
    localparam int          PROD_W      = SUM_W + MULT_W;
    localparam int          VALUE_W     = PROD_W - SCALE_SHIFT;
    localparam logic [26:0] SCALE_MULT  = 27'd83906570;

    localparam logic KIND_SAMPLE   = 1'b0;
    localparam logic KIND_TICK     = 1'b1;
    localparam logic RESULT_STATUS = 1'b0;
    localparam logic RESULT_FRAME  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_START_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 2'd3;

    localparam logic [LIMIT_W-1:0] START_LIMIT_RST   = 10'd100;
    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST     = 10'd300;
    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST    = 10'd600;
    localparam logic [ADDR_W-1:0]  SLAVE_ADDRESS_RST = 8'd1;

    localparam logic [BYTE_W-1:0] FUNC_WRITE_MULTI = 8'h10;
    localparam logic [CRC_W-1:0]  CRC_INIT         = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY         = 16'hA001;

    typedef struct packed {
        logic                                 kind;
        logic [IN_CHANNELS-1:0][SAMPLE_W-1:0] samples;
    } cmd_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] start_limit;
        logic [LIMIT_W-1:0] low_limit;
        logic [LIMIT_W-1:0] high_limit;
        logic [ADDR_W-1:0]  slave_address;
    } cfg_t;

    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

### sv/pressure_alarm_modbus_reporter.sv
// Pressure alarm reporter top level: configuration registers, front queue and back end.
// Depends on par_pkg, par_front and par_back.
// Throughput: one sample set per cycle while the back end is idle; closing an average
// scales the channels, one channel per cycle, through the shared scaling multiplier.
// The status result is registered once those channels are scaled; a tick gives its
// frame bytes one byte per cycle while m_tready is high, 25 bytes by default.
// Reset (synchronous, aresetn low) clears sums, counts, flags and the queue and loads
// the register defaults.
module pressure_alarm_modbus_reporter #(
    parameter int CHANNELS            = par_pkg::CHANNELS_DEF,
    parameter int SAMPLES_PER_AVERAGE = par_pkg::SAMPLES_PER_AVERAGE_DEF,
    parameter int REPORT_WORDS        = par_pkg::REPORT_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [par_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [par_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: sample_ch0 [11:0] up to sample_ch6 [83:72], zero padding [87:84]
    input  logic [par_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: kind [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: low_alarms [6:0], high_alarms [13:7], frame_byte [21:14], zero [23:22]
    output logic [par_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: result_kind [0]
    output logic                          m_tuser,
    output logic                          m_tlast
);

    par_pkg::cfg_t cfg_reg;
    logic          q_valid;
    par_pkg::cmd_t q_cmd;
    logic          q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_limit   <= par_pkg::START_LIMIT_RST;
            cfg_reg.low_limit     <= par_pkg::LOW_LIMIT_RST;
            cfg_reg.high_limit    <= par_pkg::HIGH_LIMIT_RST;
            cfg_reg.slave_address <= par_pkg::SLAVE_ADDRESS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                par_pkg::REG_START_LIMIT: begin
                    cfg_reg.start_limit <= cfg_wdata;
                end
                par_pkg::REG_LOW_LIMIT: begin
                    cfg_reg.low_limit <= cfg_wdata;
                end
                par_pkg::REG_HIGH_LIMIT: begin
                    cfg_reg.high_limit <= cfg_wdata;
                end
                par_pkg::REG_SLAVE_ADDRESS: begin
                    cfg_reg.slave_address <= cfg_wdata[par_pkg::ADDR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    par_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    par_back #(
        .CHANNELS            (CHANNELS),
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .REPORT_WORDS        (REPORT_WORDS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sv/par_front.sv
// Front end of the pressure alarm reporter: accepts input transfers, splits
// them into kind and channel readings, and holds them in a two-entry queue.
// Depends on par_pkg.
module par_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: sample_ch0 [11:0] up to sample_ch6 [83:72], zero padding [87:84]
    input  logic [par_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: kind [0]
    input  logic                         s_tuser,
    output logic                         q_valid,
    output par_pkg::cmd_t                q_cmd,
    input  logic                         q_pop
);

    par_pkg::cmd_t                  entry_reg [par_pkg::QUEUE_DEPTH];
    logic [par_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [par_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [par_pkg::QCNT_W-1:0]     count_reg, count_next;
    par_pkg::cmd_t                  in_cmd;
    logic                           push;
    logic                           pop;

    always_comb begin
        in_cmd.kind = s_tuser;
        for (int c = 0; c < par_pkg::IN_CHANNELS; c++) begin
            in_cmd.samples[c] = s_tdata[c*par_pkg::SAMPLE_W +: par_pkg::SAMPLE_W];
        end
    end

    assign s_tready = (count_reg != par_pkg::QCNT_W'(par_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### sv/par_back.sv
// Back end of the pressure alarm reporter: channel sums, the shared scaling
// multiplier, threshold classification, and the Modbus frame and CRC sequencer.
// Depends on par_pkg; drives the result stream through its output register.
module par_back #(
    parameter int CHANNELS            = par_pkg::CHANNELS_DEF,
    parameter int SAMPLES_PER_AVERAGE = par_pkg::SAMPLES_PER_AVERAGE_DEF,
    parameter int REPORT_WORDS        = par_pkg::REPORT_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  par_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  par_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: low_alarms [6:0], high_alarms [13:7], frame_byte [21:14], zero [23:22]
    output logic [par_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: result_kind [0]
    output logic                          m_tuser,
    output logic                          m_tlast
);

    localparam int CNT_W      = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int CH_W       = $clog2(CHANNELS + 1);
    localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FRAME_LEN  = 9 + 2 * REPORT_WORDS;
    localparam int CRC_LO_POS = 7 + 2 * REPORT_WORDS;
    localparam int BIDX_W     = $clog2(FRAME_LEN);
    localparam logic [7:0] WORD_COUNT_BYTE = 8'(REPORT_WORDS);
    localparam logic [7:0] BYTE_COUNT_BYTE = 8'(2 * REPORT_WORDS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_STATUS,
        ST_FRAME
    } state_t;

    state_t                           state_reg, state_next;
    logic [par_pkg::SUM_W-1:0]        sums_reg [CHANNELS];
    logic [par_pkg::SUM_W-1:0]        sums_next [CHANNELS];
    logic [par_pkg::SUM_W-1:0]        sample_ext [CHANNELS];
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CH_W-1:0]                  ch_reg, ch_next;
    logic [IDX_W-1:0]                 pch_reg, pch_next;
    logic                             pend_reg, pend_next;
    logic [par_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [CHANNELS-1:0]              lo_acc_reg, lo_acc_next;
    logic [CHANNELS-1:0]              hi_acc_reg, hi_acc_next;
    logic [par_pkg::FLAG_W-1:0]       low_flags_reg, low_flags_next;
    logic [par_pkg::FLAG_W-1:0]       high_flags_reg, high_flags_next;
    logic [BIDX_W-1:0]                bidx_reg, bidx_next;
    logic [par_pkg::CRC_W-1:0]        crc_reg, crc_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic                             m_tuser_reg, m_tuser_next;
    logic                             m_tlast_reg, m_tlast_next;
    logic [par_pkg::FLAG_W-1:0]       m_low_reg, m_low_next;
    logic [par_pkg::FLAG_W-1:0]       m_high_reg, m_high_next;
    logic [par_pkg::BYTE_W-1:0]       m_byte_reg, m_byte_next;
    logic [par_pkg::FLAG_W-1:0]       lo7, hi7;
    logic [par_pkg::VALUE_W-1:0]      value;
    logic [par_pkg::BYTE_W-1:0]       fbyte;
    logic [IDX_W-1:0]                 ch_idx;
    logic                             out_free;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_sample
        if (g < par_pkg::IN_CHANNELS) begin : g_in
            assign sample_ext[g] = par_pkg::SUM_W'(q_cmd.samples[g]);
        end else begin : g_zero
            assign sample_ext[g] = '0;
        end
    end

    for (genvar g = 0; g < par_pkg::FLAG_W; g++) begin : g_flag
        if (g < CHANNELS) begin : g_used
            assign lo7[g] = lo_acc_reg[g];
            assign hi7[g] = hi_acc_reg[g];
        end else begin : g_none
            assign lo7[g] = 1'b0;
            assign hi7[g] = 1'b0;
        end
    end

    assign value    = prod_reg[par_pkg::PROD_W-1:par_pkg::SCALE_SHIFT];
    assign ch_idx   = ch_reg[IDX_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        if (bidx_reg == BIDX_W'(0)) begin
            fbyte = cfg.slave_address;
        end else if (bidx_reg == BIDX_W'(1)) begin
            fbyte = par_pkg::FUNC_WRITE_MULTI;
        end else if (bidx_reg == BIDX_W'(5)) begin
            fbyte = WORD_COUNT_BYTE;
        end else if (bidx_reg == BIDX_W'(6)) begin
            fbyte = BYTE_COUNT_BYTE;
        end else if (bidx_reg == BIDX_W'(7)) begin
            fbyte = 8'(high_flags_reg);
        end else if (bidx_reg == BIDX_W'(8)) begin
            fbyte = 8'(low_flags_reg);
        end else if (bidx_reg == BIDX_W'(CRC_LO_POS)) begin
            fbyte = crc_reg[7:0];
        end else if (bidx_reg == BIDX_W'(CRC_LO_POS + 1)) begin
            fbyte = crc_reg[15:8];
        end else begin
            fbyte = '0;
        end
    end

    always_comb begin
        state_next      = state_reg;
        sums_next       = sums_reg;
        count_next      = count_reg;
        ch_next         = ch_reg;
        pch_next        = pch_reg;
        pend_next       = pend_reg;
        prod_next       = prod_reg;
        lo_acc_next     = lo_acc_reg;
        hi_acc_next     = hi_acc_reg;
        low_flags_next  = low_flags_reg;
        high_flags_next = high_flags_reg;
        bidx_next       = bidx_reg;
        crc_next        = crc_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        m_low_next      = m_low_reg;
        m_high_next     = m_high_reg;
        m_byte_next     = m_byte_reg;
        q_pop           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_cmd.kind == par_pkg::KIND_SAMPLE) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            sums_next[c] = sums_reg[c] + sample_ext[c];
                        end
                        if (count_reg == CNT_W'(SAMPLES_PER_AVERAGE - 1)) begin
                            count_next  = '0;
                            ch_next     = '0;
                            pend_next   = 1'b0;
                            lo_acc_next = '0;
                            hi_acc_next = '0;
                            state_next  = ST_SCALE;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        bidx_next  = '0;
                        crc_next   = par_pkg::CRC_INIT;
                        state_next = ST_FRAME;
                    end
                end
            end
            ST_SCALE: begin
                if (pend_reg) begin
                    if (value >= par_pkg::VALUE_W'(cfg.start_limit) &&
                        value <= par_pkg::VALUE_W'(cfg.low_limit)) begin
                        lo_acc_next[pch_reg] = 1'b1;
                    end else if (value >= par_pkg::VALUE_W'(cfg.high_limit)) begin
                        hi_acc_next[pch_reg] = 1'b1;
                    end
                end
                if (ch_reg < CH_W'(CHANNELS)) begin
                    prod_next         = par_pkg::PROD_W'(sums_reg[ch_idx]) *
                                        par_pkg::PROD_W'(par_pkg::SCALE_MULT);
                    sums_next[ch_idx] = '0;
                    pch_next          = ch_idx;
                    pend_next         = 1'b1;
                    ch_next           = ch_reg + 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    low_flags_next  = lo7;
                    high_flags_next = hi7;
                    m_tvalid_next   = 1'b1;
                    m_tuser_next    = par_pkg::RESULT_STATUS;
                    m_low_next      = lo7;
                    m_high_next     = hi7;
                    m_byte_next     = '0;
                    m_tlast_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FRAME: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = par_pkg::RESULT_FRAME;
                    m_low_next    = low_flags_reg;
                    m_high_next   = high_flags_reg;
                    m_byte_next   = fbyte;
                    if (bidx_reg < BIDX_W'(CRC_LO_POS)) begin
                        crc_next = par_pkg::crc16_byte(crc_reg, fbyte);
                    end
                    if (bidx_reg == BIDX_W'(FRAME_LEN - 1)) begin
                        m_tlast_next = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        m_tlast_next = 1'b0;
                        bidx_next    = bidx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sums_reg       <= '{default: '0};
            count_reg      <= '0;
            ch_reg         <= '0;
            pend_reg       <= 1'b0;
            lo_acc_reg     <= '0;
            hi_acc_reg     <= '0;
            low_flags_reg  <= '0;
            high_flags_reg <= '0;
            bidx_reg       <= '0;
            crc_reg        <= par_pkg::CRC_INIT;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sums_reg       <= sums_next;
            count_reg      <= count_next;
            ch_reg         <= ch_next;
            pend_reg       <= pend_next;
            lo_acc_reg     <= lo_acc_next;
            hi_acc_reg     <= hi_acc_next;
            low_flags_reg  <= low_flags_next;
            high_flags_reg <= high_flags_next;
            bidx_reg       <= bidx_next;
            crc_reg        <= crc_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        pch_reg     <= pch_next;
        prod_reg    <= prod_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        m_low_reg   <= m_low_next;
        m_high_reg  <= m_high_next;
        m_byte_reg  <= m_byte_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {2'b00, m_byte_reg, m_high_reg, m_low_reg};

endmodule
